>>> rtl/ocrd_pkg.sv
// ----------------------------------------------------------------------------
// ocrd_pkg: shared types and constants of the CAN response decoder
// Field widths, register indexes, service and parameter codes, metric codes,
// decode groups and the reciprocal constants of the divide paths.
// ----------------------------------------------------------------------------
package ocrd_pkg;

  localparam int ID_W      = 11;
  localparam int DLC_W     = 4;
  localparam int BYTE_W    = 8;
  localparam int MET_W     = 5;
  localparam int VAL_W     = 48;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIAG_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAG_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_ID  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_METER_ID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_ID  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_ID    = 3'd5;

  localparam logic [ID_W-1:0] RST_DIAG_LOW  = 11'd2024;
  localparam logic [ID_W-1:0] RST_DIAG_HIGH = 11'd2031;
  localparam logic [ID_W-1:0] RST_BRAKE_ID  = 11'd1976;
  localparam logic [ID_W-1:0] RST_METER_ID  = 11'd1992;
  localparam logic [ID_W-1:0] RST_WHEEL_ID  = 11'd170;
  localparam logic [ID_W-1:0] RST_RPM_ID    = 11'd705;

  localparam logic [BYTE_W-1:0] SRV_STD = 8'h41;
  localparam logic [BYTE_W-1:0] SRV_EXT = 8'h61;

  localparam logic [BYTE_W-1:0] PID_RPM   = 8'h0C;
  localparam logic [BYTE_W-1:0] PID_VOLT  = 8'h42;
  localparam logic [BYTE_W-1:0] PID_IAT   = 8'h0F;
  localparam logic [BYTE_W-1:0] PID_BARO  = 8'h33;
  localparam logic [BYTE_W-1:0] PID_ATF   = 8'h82;
  localparam logic [BYTE_W-1:0] PID_GEAR  = 8'h85;
  localparam logic [BYTE_W-1:0] PID_ODO   = 8'h28;
  localparam logic [BYTE_W-1:0] PID_FUEL  = 8'h29;
  localparam logic [BYTE_W-1:0] PID_WSPD  = 8'h03;
  localparam logic [BYTE_W-1:0] PID_DECEL = 8'h46;
  localparam logic [BYTE_W-1:0] PID_GFORC = 8'h47;

  // Metric codes.
  localparam logic [MET_W-1:0] M_RPM     = 5'd0;
  localparam logic [MET_W-1:0] M_VOLT    = 5'd1;
  localparam logic [MET_W-1:0] M_IAT     = 5'd2;
  localparam logic [MET_W-1:0] M_BARO    = 5'd3;
  localparam logic [MET_W-1:0] M_ATF_PAN = 5'd4;
  localparam logic [MET_W-1:0] M_ATF_TC  = 5'd5;
  localparam logic [MET_W-1:0] M_GEAR    = 5'd6;
  localparam logic [MET_W-1:0] M_LOCKUP  = 5'd7;
  localparam logic [MET_W-1:0] M_ODO     = 5'd8;
  localparam logic [MET_W-1:0] M_FUEL    = 5'd9;
  localparam logic [MET_W-1:0] M_DWHEEL  = 5'd10;
  localparam logic [MET_W-1:0] M_DECEL   = 5'd14;
  localparam logic [MET_W-1:0] M_YAW0    = 5'd16;
  localparam logic [MET_W-1:0] M_LAT_G   = 5'd17;
  localparam logic [MET_W-1:0] M_LON_G   = 5'd18;
  localparam logic [MET_W-1:0] M_YAW     = 5'd19;
  localparam logic [MET_W-1:0] M_STEER   = 5'd20;
  localparam logic [MET_W-1:0] M_BWHEEL  = 5'd21;
  localparam logic [MET_W-1:0] M_BRPM    = 5'd25;
  localparam logic [MET_W-1:0] M_LAST    = 5'd28;

  typedef enum logic [3:0] {
    GRP_NONE, GRP_WHEEL, GRP_RPMB, GRP_RPM, GRP_VOLT, GRP_IAT, GRP_BARO, GRP_ATF,
    GRP_GEAR, GRP_ODO, GRP_FUEL, GRP_WSPD, GRP_DECEL, GRP_GFORC
  } ocrd_grp_t;

  // Which odd divisor a slot goes through; the power-of-two part is a shift.
  typedef enum logic [1:0] {DIV_NONE, DIV_25, DIV_125, DIV_5} ocrd_div_t;

  localparam int U_W    = 17;
  localparam int RCP_W  = 18;
  localparam int PROD_W = U_W + RCP_W;
  localparam int QA_W   = 14;
  localparam int REM_W  = 7;

  // ceil(2^s / m), exact for any dividend below 2^17.
  localparam logic [RCP_W-1:0] RCP_25  = 18'd167773;
  localparam logic [RCP_W-1:0] RCP_125 = 18'd134218;
  localparam logic [RCP_W-1:0] RCP_5   = 18'd209716;
  localparam int SH_25  = 22;
  localparam int SH_125 = 24;
  localparam int SH_5   = 20;

endpackage

>>> rtl/ocrd_ifs.sv
// ----------------------------------------------------------------------------
// ocrd_ifs: stream interfaces of the CAN response decoder
// A frame channel and a metric update channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface ocrd_frame_if;
  logic                          valid;
  logic                          ready;
  logic [ocrd_pkg::ID_W-1:0]     frame_id;
  logic [ocrd_pkg::DLC_W-1:0]    length_code;
  logic [ocrd_pkg::BYTE_W-1:0]   data0;
  logic [ocrd_pkg::BYTE_W-1:0]   data1;
  logic [ocrd_pkg::BYTE_W-1:0]   data2;
  logic [ocrd_pkg::BYTE_W-1:0]   data3;
  logic [ocrd_pkg::BYTE_W-1:0]   data4;
  logic [ocrd_pkg::BYTE_W-1:0]   data5;
  logic [ocrd_pkg::BYTE_W-1:0]   data6;
  logic [ocrd_pkg::BYTE_W-1:0]   data7;

  modport source (output valid, frame_id, length_code, data0, data1, data2, data3,
                  data4, data5, data6, data7, input ready);
  modport sink (input valid, frame_id, length_code, data0, data1, data2, data3,
                data4, data5, data6, data7, output ready);
endinterface

interface ocrd_result_if;
  logic                              valid;
  logic                              ready;
  logic [ocrd_pkg::MET_W-1:0]        metric;
  logic signed [ocrd_pkg::VAL_W-1:0] value;
  logic                              last;

  modport source (output valid, metric, value, last, input ready);
  modport sink (input valid, metric, value, last, output ready);
endinterface

>>> rtl/obd_can_response_decoder_core.sv
// ----------------------------------------------------------------------------
// obd_can_response_decoder_core: CAN frame to metric update decoder
// Classifies a received frame and turns it into zero to four fixed-point
// metric updates through a five-stage pipeline and an output serializer.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one received frame per request (id, DLC, eight data bytes).
//   out_if carries metric updates (metric code, signed value with FRACTION_BITS
//   fraction bits, last flag on the final update of a frame).
//   cfg_we/cfg_index/cfg_data write the identifier registers; write them only
//   while the block is idle.
// Timing:
//   The first update of a frame appears after it passes stages s1 to s5 and
//   the serializer register. A frame that yields n updates holds the output
//   serializer until its last update is taken; a new frame loads only then.
//   Frames that decode to nothing are dropped at the input.
// Reset:
//   rst_n clears all pipeline valid bits and loads the default identifiers.
// Stall:
//   When out_if.ready is low, the pipeline stages fill one by one and then
//   in_if.ready drops; no request is lost or repeated.
// ----------------------------------------------------------------------------
module obd_can_response_decoder_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ocrd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ocrd_pkg::ID_W-1:0]        cfg_data,
  ocrd_frame_if.sink                       in_if,
  ocrd_result_if.source                    out_if
);

  localparam int FB = FRACTION_BITS;
  localparam logic signed [63:0] VMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

  typedef logic signed [ocrd_pkg::VAL_W-1:0] tbl256_t [256];
  typedef logic [23:0] frac25_t [25];
  typedef logic [23:0] frac125_t [125];
  typedef logic [23:0] frac5_t [5];

  function automatic tbl256_t fuel_fn();
    tbl256_t t;
    longint  p;
    for (int i = 0; i < 256; i++) begin
      p = longint'(i) * 64'sd500 * (64'sd1 <<< FB);
      t[i] = 48'(p / 64'sd3785);
    end
    return t;
  endfunction

  function automatic tbl256_t wspd_fn();
    tbl256_t t;
    longint  p;
    for (int i = 0; i < 256; i++) begin
      p = longint'(i) * 64'sd256 * (64'sd1 <<< FB);
      t[i] = 48'(p / 64'sd200);
    end
    return t;
  endfunction

  function automatic tbl256_t gforc_fn();
    tbl256_t t;
    longint  p;
    longint  q;
    for (int i = 0; i < 256; i++) begin
      p = ((i >= 128) ? longint'(i) - 64'sd256 : longint'(i)) * (64'sd1 <<< FB);
      q = p / 64'sd50;
      if ((p % 64'sd50) != 0 && p < 0) q = q - 64'sd1;
      t[i] = 48'(q);
    end
    return t;
  endfunction

  function automatic tbl256_t decel_fn();
    tbl256_t t;
    longint  p;
    longint  q;
    for (int i = 0; i < 256; i++) begin
      p = (longint'(i) * 64'sd1961568627 - 64'sd251100000000) * (64'sd1 <<< FB);
      q = p / 64'sd10000000000;
      if ((p % 64'sd10000000000) != 0 && p < 0) q = q - 64'sd1;
      t[i] = 48'(q);
    end
    return t;
  endfunction

  // Fraction tables: floor(r * 2^G / m) for each remainder r of the odd divisor.
  function automatic frac25_t frac25_fn();
    frac25_t t;
    for (int i = 0; i < 25; i++) t[i] = 24'((longint'(i) <<< (FB - 2)) / 64'sd25);
    return t;
  endfunction

  function automatic frac125_t frac125_fn();
    frac125_t t;
    for (int i = 0; i < 125; i++) t[i] = 24'((longint'(i) <<< (FB - 3)) / 64'sd125);
    return t;
  endfunction

  function automatic frac5_t frac5_fn();
    frac5_t t;
    for (int i = 0; i < 5; i++) t[i] = 24'((longint'(i) <<< (FB - 1)) / 64'sd5);
    return t;
  endfunction

  localparam tbl256_t  FUEL_TBL  = fuel_fn();
  localparam tbl256_t  WSPD_TBL  = wspd_fn();
  localparam tbl256_t  GFORC_TBL = gforc_fn();
  localparam tbl256_t  DECEL_TBL = decel_fn();
  localparam frac25_t  FRAC25    = frac25_fn();
  localparam frac125_t FRAC125   = frac125_fn();
  localparam frac5_t   FRAC5     = frac5_fn();

  function automatic logic signed [63:0] ux(logic [23:0] x);
    return signed'(64'(x));
  endfunction

  // Configuration registers.
  logic [ocrd_pkg::ID_W-1:0] diag_lo_r, diag_hi_r, brake_id_r, meter_id_r;
  logic [ocrd_pkg::ID_W-1:0] wheel_id_r, rpm_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diag_lo_r  <= ocrd_pkg::RST_DIAG_LOW;
      diag_hi_r  <= ocrd_pkg::RST_DIAG_HIGH;
      brake_id_r <= ocrd_pkg::RST_BRAKE_ID;
      meter_id_r <= ocrd_pkg::RST_METER_ID;
      wheel_id_r <= ocrd_pkg::RST_WHEEL_ID;
      rpm_id_r   <= ocrd_pkg::RST_RPM_ID;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ocrd_pkg::CFG_DIAG_LOW:  diag_lo_r  <= cfg_data;
        ocrd_pkg::CFG_DIAG_HIGH: diag_hi_r  <= cfg_data;
        ocrd_pkg::CFG_BRAKE_ID:  brake_id_r <= cfg_data;
        ocrd_pkg::CFG_METER_ID:  meter_id_r <= cfg_data;
        ocrd_pkg::CFG_WHEEL_ID:  wheel_id_r <= cfg_data;
        ocrd_pkg::CFG_RPM_ID:    rpm_id_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input decode.
  logic [7:0]          in_d [8];
  ocrd_pkg::ocrd_grp_t grp_nxt;
  logic                diag_hit;

  assign in_d[0] = in_if.data0;
  assign in_d[1] = in_if.data1;
  assign in_d[2] = in_if.data2;
  assign in_d[3] = in_if.data3;
  assign in_d[4] = in_if.data4;
  assign in_d[5] = in_if.data5;
  assign in_d[6] = in_if.data6;
  assign in_d[7] = in_if.data7;

  assign diag_hit = (in_if.frame_id >= diag_lo_r && in_if.frame_id <= diag_hi_r) ||
                    in_if.frame_id == brake_id_r || in_if.frame_id == meter_id_r;

  always_comb begin
    grp_nxt = ocrd_pkg::GRP_NONE;
    if (in_if.frame_id == wheel_id_r) begin
      if (in_if.length_code >= 4'd8) grp_nxt = ocrd_pkg::GRP_WHEEL;
    end else if (in_if.frame_id == rpm_id_r) begin
      if (in_if.length_code >= 4'd8) grp_nxt = ocrd_pkg::GRP_RPMB;
    end else if (diag_hit && in_if.length_code >= 4'd3 && in_d[0] >= 8'd2) begin
      if (in_d[1] == ocrd_pkg::SRV_STD) begin
        case (in_d[2])
          ocrd_pkg::PID_RPM:  if (in_d[0] >= 8'd4) grp_nxt = ocrd_pkg::GRP_RPM;
          ocrd_pkg::PID_VOLT: if (in_d[0] >= 8'd4) grp_nxt = ocrd_pkg::GRP_VOLT;
          ocrd_pkg::PID_IAT:  if (in_d[0] >= 8'd3) grp_nxt = ocrd_pkg::GRP_IAT;
          ocrd_pkg::PID_BARO: if (in_d[0] >= 8'd3) grp_nxt = ocrd_pkg::GRP_BARO;
          default: ;
        endcase
      end else if (in_d[1] == ocrd_pkg::SRV_EXT) begin
        case (in_d[2])
          ocrd_pkg::PID_ATF:   if (in_d[0] >= 8'd6) grp_nxt = ocrd_pkg::GRP_ATF;
          ocrd_pkg::PID_GEAR:  if (in_d[0] >= 8'd5) grp_nxt = ocrd_pkg::GRP_GEAR;
          ocrd_pkg::PID_ODO:   if (in_d[0] >= 8'd5) grp_nxt = ocrd_pkg::GRP_ODO;
          ocrd_pkg::PID_FUEL:  if (in_d[0] >= 8'd3) grp_nxt = ocrd_pkg::GRP_FUEL;
          ocrd_pkg::PID_WSPD:  if (in_d[0] >= 8'd7) grp_nxt = ocrd_pkg::GRP_WSPD;
          ocrd_pkg::PID_DECEL: if (in_d[0] >= 8'd5) grp_nxt = ocrd_pkg::GRP_DECEL;
          ocrd_pkg::PID_GFORC: if (in_d[0] >= 8'd7) grp_nxt = ocrd_pkg::GRP_GFORC;
          default: ;
        endcase
      end
    end
  end

  // Pipeline registers.
  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic                 en1, en2, en3, en4, en5, ser_free;
  ocrd_pkg::ocrd_grp_t  s1_grp_r;
  logic [7:0]           s1_d_r [8];

  logic [2:0]                       s2_cnt_r, s3_cnt_r, s4_cnt_r, s5_cnt_r;
  logic [ocrd_pkg::MET_W-1:0]       s2_met_r [4], s3_met_r [4], s4_met_r [4], s5_met_r [4];
  ocrd_pkg::ocrd_div_t              s2_div_r [4], s3_div_r [4], s4_div_r [4];
  logic [ocrd_pkg::U_W-1:0]         s2_u_r [4], s3_u_r [4];
  logic signed [63:0]               s2_dir_r [4], s3_dir_r [4], s4_dir_r [4];
  logic [ocrd_pkg::PROD_W-1:0]      s3_prod_r [4];
  logic [ocrd_pkg::QA_W-1:0]        s4_a_r [4];
  logic [ocrd_pkg::REM_W-1:0]       s4_r_r [4];
  logic signed [ocrd_pkg::VAL_W-1:0] s5_val_r [4];

  logic                             ser_v_r;
  logic [2:0]                       ser_cnt_r;
  logic [1:0]                       ser_idx_r;
  logic [ocrd_pkg::MET_W-1:0]       ser_met_r [4];
  logic signed [ocrd_pkg::VAL_W-1:0] ser_val_r [4];
  logic                             out_last;

  assign out_last = ({1'b0, ser_idx_r} == ser_cnt_r - 3'd1);
  assign ser_free = !ser_v_r || (out_if.ready && out_last);
  assign en5 = !s5_v_r || ser_free;
  assign en4 = !s4_v_r || en5;
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;
  assign in_if.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      ser_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_if.valid && grp_nxt != ocrd_pkg::GRP_NONE;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
      if (en5) s5_v_r <= s4_v_r;
      if (ser_free) ser_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_grp_r <= grp_nxt;
      for (int i = 0; i < 8; i++) s1_d_r[i] <= in_d[i];
    end
  end

  // Stage 2: per-slot metric codes, divider operands and direct values.
  logic [2:0]                 cnt_nxt;
  logic [ocrd_pkg::MET_W-1:0] met_nxt [4];
  ocrd_pkg::ocrd_div_t        div_nxt [4];
  logic [ocrd_pkg::U_W-1:0]   u_nxt [4];
  logic signed [63:0]         dir_nxt [4];
  logic signed [17:0]         wraw;

  always_comb begin
    cnt_nxt = 3'd1;
    wraw    = '0;
    for (int k = 0; k < 4; k++) begin
      met_nxt[k] = ocrd_pkg::M_RPM;
      div_nxt[k] = ocrd_pkg::DIV_NONE;
      u_nxt[k]   = '0;
      dir_nxt[k] = '0;
    end
    case (s1_grp_r)
      ocrd_pkg::GRP_WHEEL: begin
        cnt_nxt = 3'd4;
        for (int k = 0; k < 4; k++) begin
          met_nxt[k] = ocrd_pkg::M_BWHEEL + 5'(k);
          div_nxt[k] = ocrd_pkg::DIV_25;
          // raw - 6770 plus 1600 * 25 keeps the dividend positive.
          wraw = 18'(signed'({s1_d_r[2*k], s1_d_r[2*k+1]})) + 18'sd33230;
          u_nxt[k] = wraw[16:0];
        end
      end
      ocrd_pkg::GRP_RPMB: begin
        cnt_nxt = 3'd4;
        for (int k = 0; k < 4; k++) met_nxt[k] = ocrd_pkg::M_BRPM + 5'(k);
        dir_nxt[0] = ux(24'(s1_d_r[2])) <<< (FB + 3);
        dir_nxt[1] = ux(24'(s1_d_r[4])) <<< (FB + 3);
        dir_nxt[2] = ux(24'(s1_d_r[7])) <<< (FB + 3);
        dir_nxt[3] = ux(24'({s1_d_r[5], s1_d_r[4]})) <<< (FB - 3);
      end
      ocrd_pkg::GRP_RPM: begin
        met_nxt[0] = ocrd_pkg::M_RPM;
        dir_nxt[0] = ux(24'({s1_d_r[3], s1_d_r[4]})) <<< (FB - 2);
      end
      ocrd_pkg::GRP_VOLT: begin
        met_nxt[0] = ocrd_pkg::M_VOLT;
        div_nxt[0] = ocrd_pkg::DIV_125;
        u_nxt[0]   = {1'b0, s1_d_r[3], s1_d_r[4]};
      end
      ocrd_pkg::GRP_IAT: begin
        met_nxt[0] = ocrd_pkg::M_IAT;
        dir_nxt[0] = (ux(24'(s1_d_r[3])) - 64'sd40) <<< FB;
      end
      ocrd_pkg::GRP_BARO: begin
        met_nxt[0] = ocrd_pkg::M_BARO;
        dir_nxt[0] = ux(24'(s1_d_r[3])) <<< FB;
      end
      ocrd_pkg::GRP_ATF: begin
        cnt_nxt    = 3'd2;
        met_nxt[0] = ocrd_pkg::M_ATF_PAN;
        met_nxt[1] = ocrd_pkg::M_ATF_TC;
        dir_nxt[0] = (ux(24'({s1_d_r[3], s1_d_r[4]})) - 64'sd10240) <<< (FB - 8);
        dir_nxt[1] = (ux(24'({s1_d_r[5], s1_d_r[6]})) - 64'sd10240) <<< (FB - 8);
      end
      ocrd_pkg::GRP_GEAR: begin
        cnt_nxt    = 3'd2;
        met_nxt[0] = ocrd_pkg::M_GEAR;
        met_nxt[1] = ocrd_pkg::M_LOCKUP;
        dir_nxt[0] = ux(24'(s1_d_r[3])) <<< FB;
        dir_nxt[1] = ux(24'(s1_d_r[4][7])) <<< FB;
      end
      ocrd_pkg::GRP_ODO: begin
        met_nxt[0] = ocrd_pkg::M_ODO;
        dir_nxt[0] = ux({s1_d_r[3], s1_d_r[4], s1_d_r[5]}) <<< FB;
      end
      ocrd_pkg::GRP_FUEL: begin
        met_nxt[0] = ocrd_pkg::M_FUEL;
        dir_nxt[0] = 64'(FUEL_TBL[s1_d_r[3]]);
      end
      ocrd_pkg::GRP_WSPD: begin
        cnt_nxt = 3'd4;
        for (int k = 0; k < 4; k++) begin
          met_nxt[k] = ocrd_pkg::M_DWHEEL + 5'(k);
          dir_nxt[k] = 64'(WSPD_TBL[s1_d_r[3+k]]);
        end
      end
      ocrd_pkg::GRP_DECEL: begin
        cnt_nxt    = 3'd3;
        met_nxt[0] = ocrd_pkg::M_DECEL;
        met_nxt[1] = ocrd_pkg::M_DECEL + 5'd1;
        met_nxt[2] = ocrd_pkg::M_YAW0;
        dir_nxt[0] = 64'(DECEL_TBL[s1_d_r[3]]);
        dir_nxt[1] = 64'(DECEL_TBL[s1_d_r[4]]);
        dir_nxt[2] = (ux(24'(s1_d_r[5])) - 64'sd128) <<< FB;
      end
      ocrd_pkg::GRP_GFORC: begin
        cnt_nxt    = 3'd4;
        met_nxt[0] = ocrd_pkg::M_LAT_G;
        met_nxt[1] = ocrd_pkg::M_LON_G;
        met_nxt[2] = ocrd_pkg::M_YAW;
        met_nxt[3] = ocrd_pkg::M_STEER;
        dir_nxt[0] = 64'(GFORC_TBL[s1_d_r[3]]);
        dir_nxt[1] = 64'(GFORC_TBL[s1_d_r[4]]);
        dir_nxt[2] = (ux(24'(s1_d_r[5])) - 64'sd128) <<< FB;
        div_nxt[3] = ocrd_pkg::DIV_5;
        // Angle minus 32768 plus 6554 * 5.
        u_nxt[3]   = 17'({s1_d_r[6], s1_d_r[7]}) + 17'd2;
      end
      default: ;
    endcase
  end

  // Stage 4 and 5 combinational parts.
  logic [ocrd_pkg::PROD_W-1:0] qfull [4];
  logic [ocrd_pkg::QA_W-1:0]   a_nxt [4];
  logic [ocrd_pkg::U_W-1:0]    am [4];
  logic [ocrd_pkg::REM_W-1:0]  r_nxt [4];
  logic signed [63:0]          v64 [4];
  logic signed [ocrd_pkg::VAL_W-1:0] val_nxt [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      case (s3_div_r[k])
        ocrd_pkg::DIV_25: begin
          qfull[k] = s3_prod_r[k] >> ocrd_pkg::SH_25;
          a_nxt[k] = qfull[k][ocrd_pkg::QA_W-1:0];
          am[k]    = 17'({3'b0, a_nxt[k]} * 17'd25);
        end
        ocrd_pkg::DIV_125: begin
          qfull[k] = s3_prod_r[k] >> ocrd_pkg::SH_125;
          a_nxt[k] = qfull[k][ocrd_pkg::QA_W-1:0];
          am[k]    = 17'({3'b0, a_nxt[k]} * 17'd125);
        end
        ocrd_pkg::DIV_5: begin
          qfull[k] = s3_prod_r[k] >> ocrd_pkg::SH_5;
          a_nxt[k] = qfull[k][ocrd_pkg::QA_W-1:0];
          am[k]    = 17'({3'b0, a_nxt[k]} * 17'd5);
        end
        default: begin
          qfull[k] = '0;
          a_nxt[k] = '0;
          am[k]    = '0;
        end
      endcase
      r_nxt[k] = 7'(s3_u_r[k] - am[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      case (s4_div_r[k])
        ocrd_pkg::DIV_25:
          v64[k] = ((ux(24'(s4_a_r[k])) - 64'sd1600) <<< (FB - 2)) +
                   ux(FRAC25[s4_r_r[k][4:0]]);
        ocrd_pkg::DIV_125:
          v64[k] = (ux(24'(s4_a_r[k])) <<< (FB - 3)) + ux(FRAC125[s4_r_r[k][6:0]]);
        ocrd_pkg::DIV_5:
          v64[k] = ((ux(24'(s4_a_r[k])) - 64'sd6554) <<< (FB - 1)) +
                   ux(FRAC5[s4_r_r[k][2:0]]);
        default:
          v64[k] = s4_dir_r[k];
      endcase
      if (v64[k] > VMAX)      val_nxt[k] = VMAX[ocrd_pkg::VAL_W-1:0];
      else if (v64[k] < VMIN) val_nxt[k] = VMIN[ocrd_pkg::VAL_W-1:0];
      else                    val_nxt[k] = v64[k][ocrd_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_cnt_r <= cnt_nxt;
      for (int k = 0; k < 4; k++) begin
        s2_met_r[k] <= met_nxt[k];
        s2_div_r[k] <= div_nxt[k];
        s2_u_r[k]   <= u_nxt[k];
        s2_dir_r[k] <= dir_nxt[k];
      end
    end
    if (en3) begin
      s3_cnt_r <= s2_cnt_r;
      for (int k = 0; k < 4; k++) begin
        s3_met_r[k] <= s2_met_r[k];
        s3_div_r[k] <= s2_div_r[k];
        s3_u_r[k]   <= s2_u_r[k];
        s3_dir_r[k] <= s2_dir_r[k];
        case (s2_div_r[k])
          ocrd_pkg::DIV_25:  s3_prod_r[k] <= 35'(s2_u_r[k]) * 35'(ocrd_pkg::RCP_25);
          ocrd_pkg::DIV_125: s3_prod_r[k] <= 35'(s2_u_r[k]) * 35'(ocrd_pkg::RCP_125);
          default:           s3_prod_r[k] <= 35'(s2_u_r[k]) * 35'(ocrd_pkg::RCP_5);
        endcase
      end
    end
    if (en4) begin
      s4_cnt_r <= s3_cnt_r;
      for (int k = 0; k < 4; k++) begin
        s4_met_r[k] <= s3_met_r[k];
        s4_div_r[k] <= s3_div_r[k];
        s4_dir_r[k] <= s3_dir_r[k];
        s4_a_r[k]   <= a_nxt[k];
        s4_r_r[k]   <= r_nxt[k];
      end
    end
    if (en5) begin
      s5_cnt_r <= s4_cnt_r;
      for (int k = 0; k < 4; k++) begin
        s5_met_r[k] <= s4_met_r[k];
        s5_val_r[k] <= val_nxt[k];
      end
    end
    if (ser_free) begin
      ser_cnt_r <= s5_cnt_r;
      for (int k = 0; k < 4; k++) begin
        ser_met_r[k] <= s5_met_r[k];
        ser_val_r[k] <= s5_val_r[k];
      end
    end
  end

  // Serializer index: advances one update per accepted output transfer, back to zero when the serializer is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_idx_r <= 2'd0;
    end else if (ser_free) begin
      ser_idx_r <= 2'd0;
    end else if (out_if.valid && out_if.ready) begin
      ser_idx_r <= ser_idx_r + 2'd1;
    end
  end

  assign out_if.valid  = ser_v_r;
  assign out_if.metric = ser_met_r[ser_idx_r];
  assign out_if.value  = ser_val_r[ser_idx_r];
  assign out_if.last   = out_last;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_v_r |-> ({1'b0, ser_idx_r} < ser_cnt_r))
    else $error("serializer index beyond update count");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_if.ready)
    else $error("input stalled with empty first stage");

  a_metric_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.metric <= ocrd_pkg::M_LAST))
    else $error("metric code out of range");

  a_s5_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_v_r && !en5) |=> (s5_v_r && $stable(s5_cnt_r)))
    else $error("stalled stage lost its item");

endmodule
